/* hw/rtl/aasd_pkg.sv */
// Shared types, constants and the segment decode table for the accelerometer
// average / seven-segment display unit. No dependencies.
package aasd_pkg;

    localparam int AXES       = 3;
    localparam int LANE_LAT   = 6;   // register levels from accept to lane result
    localparam int OUT_DEPTH  = 8;   // result queue entries (credit pool)

    localparam logic       REQ_TICK   = 1'b0;
    localparam logic       REQ_BUTTON = 1'b1;
    localparam logic [7:0] HOLD_RESET = 8'd200;
    localparam logic [1:0] AXIS_LAST  = 2'd2;

    // average magnitude is at most 256, scaled value at most 201
    localparam int AVG_W      = 9;
    localparam int MAG_W      = 8;
    localparam int SCALE_NUM  = 100;
    localparam int SCALE_DEN  = 127;
    localparam int SCALE_K    = 9;
    localparam int SCALE_M    = (SCALE_NUM * (2 ** SCALE_K)) / SCALE_DEN;
    localparam int SCALE_MW   = 9;
    localparam int SCALE_PW   = 15;  // width of avg*100

    // x/10 == (x*205)>>11 for x below 1029
    localparam int DIV10_M    = 205;
    localparam int DIV10_S    = 11;
    localparam int DIV10_W    = 15;

    localparam logic [3:0] SYM_S     = 4'd5;
    localparam logic [3:0] SYM_O     = 4'd10;
    localparam logic [3:0] SYM_DASH  = 4'd11;
    localparam logic [3:0] SYM_BLANK = 4'd12;

    localparam logic [7:0] SEG_DOT   = 8'h80;

    typedef struct packed {
        logic       valid;
        logic [3:0] com_n;
        logic [1:0] digit;
        logic [1:0] axis;
        logic       hold;
    } ctrl_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } lane_res_t;

    typedef struct packed {
        logic       pad;
        logic [8:0] accel_z;
        logic [8:0] accel_y;
        logic [8:0] accel_x;
        logic [7:0] segment_drive;
        logic [3:0] com_enable_n;
    } beat_t;

    function automatic logic [7:0] seg_code(input logic [3:0] sym);
        logic [7:0] code;
        case (sym)
            4'd0:      code = 8'h3F;
            4'd1:      code = 8'h06;
            4'd2:      code = 8'h5B;
            4'd3:      code = 8'h4F;
            4'd4:      code = 8'h66;
            4'd5:      code = 8'h6D;
            4'd6:      code = 8'h7D;
            4'd7:      code = 8'h07;
            4'd8:      code = 8'h7F;
            4'd9:      code = 8'h6F;
            SYM_O:     code = 8'h5C;
            SYM_DASH:  code = 8'h40;
            default:   code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

/* hw/rtl/aasd_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module aasd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 50
) (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                     wdata,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata <= mem[addr];
            end
        end
    end

endmodule

/* hw/rtl/aasd_lane.sv */
// One axis lane: sample ring, running sum and the two-step scaling.
// Uses aasd_pkg and aasd_ram.
module aasd_lane #(
    parameter int FILTER_LEN = 50
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  logic [(FILTER_LEN > 1 ? $clog2(FILTER_LEN) : 1)-1:0] addr,
    input  logic                                          old_ok,
    input  logic signed [7:0]                             sample,
    output aasd_pkg::lane_res_t                           res
);

    localparam int PW  = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
    localparam int SW  = $clog2(FILTER_LEN * 128 + 1) + 1;
    localparam int NW  = $clog2(FILTER_LEN * 256 + 1);
    localparam int K1  = NW;
    localparam int M1  = (2 ** K1) / FILTER_LEN;
    localparam int MW  = K1 + 1;
    localparam int PRW = NW + MW;
    localparam int AW  = aasd_pkg::AVG_W;
    localparam int SPW = aasd_pkg::SCALE_PW;
    localparam int EPW = aasd_pkg::AVG_W + aasd_pkg::SCALE_MW;

    // stage A: ring read in flight
    logic                 a_valid_reg;
    logic [PW-1:0]        a_addr_reg;
    logic                 a_old_ok_reg;
    logic signed [7:0]    a_sample_reg;
    logic [7:0]           ring_rdata;
    logic signed [7:0]    old_val;

    // stage B: sum update
    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic signed [SW-1:0] b_sum_reg;

    // stage C: magnitude times reciprocal of the length
    logic signed [SW:0]   twice;
    logic [SW:0]          twice_abs;
    logic [NW-1:0]        c_n_reg;
    logic [PRW-1:0]       c_prod_reg;
    logic                 c_neg_reg;

    // stage D: quotient correction
    logic [MW-1:0]        d_q0_full;
    logic [AW-1:0]        d_q0;
    logic [NW:0]          d_rem;
    logic [AW-1:0]        d_avg_reg;
    logic                 d_neg_reg;

    // stage E/F: times 100/127
    logic [EPW-1:0]       e_prod_reg;
    logic [AW-1:0]        e_avg_reg;
    logic                 e_neg_reg;
    logic [AW-1:0]        f_q0;
    logic [SPW-1:0]       f_rem;
    aasd_pkg::lane_res_t  f_res_reg;

    aasd_ram #(
        .WIDTH (8),
        .DEPTH (FILTER_LEN)
    ) u_ring (
        .clk   (clk),
        .en    (load | a_valid_reg),
        .we    (a_valid_reg),
        .addr  (a_valid_reg ? a_addr_reg : addr),
        .wdata (a_sample_reg),
        .rdata (ring_rdata)
    );

    assign old_val   = a_old_ok_reg ? signed'(ring_rdata) : 8'sd0;
    assign sum_next  = sum_reg + SW'(a_sample_reg) - SW'(old_val);

    assign twice     = {b_sum_reg, 1'b0};
    assign twice_abs = b_sum_reg[SW-1] ? $unsigned(-twice) : $unsigned(twice);

    assign d_q0_full = c_prod_reg[PRW-1:K1];
    assign d_q0      = d_q0_full[AW-1:0];
    assign d_rem     = {1'b0, c_n_reg} - (NW+1)'(d_q0) * (NW+1)'(FILTER_LEN);

    assign f_q0      = e_prod_reg[EPW-1:aasd_pkg::SCALE_K];
    assign f_rem     = SPW'(e_avg_reg) * SPW'(aasd_pkg::SCALE_NUM)
                     - SPW'(f_q0) * SPW'(aasd_pkg::SCALE_DEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= load;
            if (a_valid_reg)
            begin
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg   <= addr;
        a_old_ok_reg <= old_ok;
        a_sample_reg <= sample;

        b_sum_reg    <= sum_next;

        c_n_reg      <= twice_abs[NW-1:0];
        c_prod_reg   <= PRW'(twice_abs[NW-1:0]) * PRW'(M1);
        c_neg_reg    <= b_sum_reg[SW-1];

        d_avg_reg    <= d_q0 + AW'(d_rem >= (NW+1)'(FILTER_LEN));
        d_neg_reg    <= c_neg_reg;

        e_prod_reg   <= EPW'(d_avg_reg) * EPW'(aasd_pkg::SCALE_M);
        e_avg_reg    <= d_avg_reg;
        e_neg_reg    <= d_neg_reg;

        f_res_reg.mag <= aasd_pkg::MAG_W'(f_q0 + AW'(f_rem >= SPW'(aasd_pkg::SCALE_DEN)));
        f_res_reg.neg <= e_neg_reg;
    end

    assign res = f_res_reg;

endmodule

/* hw/rtl/aasd_merge.sv */
// Merge stage: picks the shown axis, splits it into digits and rebuilds the
// digit buffer; emits one result beat per tick. Uses aasd_pkg.
module aasd_merge (
    input  logic                           clk,
    input  logic                           rst_n,
    input  aasd_pkg::ctrl_t                ctrl,
    input  aasd_pkg::lane_res_t [2:0]      res,
    output logic                           beat_valid,
    output aasd_pkg::beat_t                beat
);

    localparam int MW = aasd_pkg::MAG_W;

    aasd_pkg::lane_res_t sel;
    logic [1:0]          hund;
    logic [MW-1:0]       rem_full;
    logic [8:0]          val [3];

    aasd_pkg::ctrl_t     m1_ctrl_reg;
    logic [1:0]          m1_hund_reg;
    logic [6:0]          m1_rem_reg;
    logic                m1_neg_reg;
    logic [8:0]          m1_val_reg [3];

    logic [aasd_pkg::DIV10_W-1:0] tens_prod;
    aasd_pkg::ctrl_t     m2_ctrl_reg;
    logic [1:0]          m2_hund_reg;
    logic [6:0]          m2_rem_reg;
    logic [3:0]          m2_tens_reg;
    logic                m2_neg_reg;
    logic [8:0]          m2_val_reg [3];

    logic [6:0]          ones_full;
    logic [3:0]          sym [4];
    logic [3:0]          dot_mask;
    logic [7:0]          pat_reg [4];
    logic [7:0]          pat_next [4];

    always_comb
    begin
        case (ctrl.axis)
            2'd1:    sel = res[1];
            2'd2:    sel = res[2];
            default: sel = res[0];
        endcase
    end

    always_comb
    begin
        if (sel.mag >= MW'(200))
        begin
            hund = 2'd2;
        end
        else if (sel.mag >= MW'(100))
        begin
            hund = 2'd1;
        end
        else
        begin
            hund = 2'd0;
        end
        rem_full = sel.mag - MW'(hund) * MW'(100);
    end

    for (genvar k = 0; k < aasd_pkg::AXES; k++)
    begin : g_val
        assign val[k] = res[k].neg ? 9'd0 - 9'(res[k].mag) : 9'(res[k].mag);
    end

    assign tens_prod = aasd_pkg::DIV10_W'(m1_rem_reg) * aasd_pkg::DIV10_W'(aasd_pkg::DIV10_M);
    assign ones_full = m2_rem_reg - 7'(m2_tens_reg) * 7'(10);

    always_comb
    begin
        if (m2_ctrl_reg.hold)
        begin
            sym[0]   = aasd_pkg::SYM_O;
            sym[1]   = aasd_pkg::SYM_S;
            sym[2]   = aasd_pkg::SYM_BLANK;
            sym[3]   = {2'b00, m2_ctrl_reg.axis};
            dot_mask = 4'b0000;
        end
        else
        begin
            sym[0]   = m2_neg_reg ? aasd_pkg::SYM_DASH : aasd_pkg::SYM_BLANK;
            sym[1]   = {2'b00, m2_hund_reg};
            sym[2]   = m2_tens_reg;
            sym[3]   = ones_full[3:0];
            dot_mask = 4'b0010;
        end
        for (int k = 0; k < 4; k++)
        begin
            pat_next[k] = aasd_pkg::seg_code(sym[k]) | (dot_mask[k] ? aasd_pkg::SEG_DOT : 8'h00);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_ctrl_reg <= '0;
            m2_ctrl_reg <= '0;
            for (int k = 0; k < 4; k++)
            begin
                pat_reg[k] <= 8'h00;
            end
        end
        else
        begin
            m1_ctrl_reg <= ctrl;
            m2_ctrl_reg <= m1_ctrl_reg;
            if (m2_ctrl_reg.valid)
            begin
                pat_reg <= pat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m1_hund_reg       <= hund;
        m1_rem_reg        <= rem_full[6:0];
        m1_neg_reg        <= sel.neg && (sel.mag != '0);
        m1_val_reg        <= val;

        m2_hund_reg       <= m1_hund_reg;
        m2_rem_reg        <= m1_rem_reg;
        m2_tens_reg       <= tens_prod[aasd_pkg::DIV10_S +: 4];
        m2_neg_reg        <= m1_neg_reg;
        m2_val_reg        <= m1_val_reg;
    end

    // segments come from the buffer built by the previous tick
    assign beat_valid         = m2_ctrl_reg.valid;
    assign beat.pad           = 1'b0;
    assign beat.com_enable_n  = m2_ctrl_reg.com_n;
    assign beat.segment_drive = pat_reg[m2_ctrl_reg.digit];
    assign beat.accel_x       = m2_val_reg[0];
    assign beat.accel_y       = m2_val_reg[1];
    assign beat.accel_z       = m2_val_reg[2];

endmodule

/* hw/rtl/aasd_fifo.sv */
// Small register-based result queue between the merge stage and the
// output stream. No dependencies.
module aasd_fifo #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTRW = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg;
    logic [PTRW-1:0]  rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign rdata     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNTW'(push) - CNTW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg < CNTW'(DEPTH)))
        else $error("result queue written while full");

endmodule

/* hw/rtl/accel_average_seven_segment_display_unit.sv */
// A tick beat's result goes through the lane, merge and queue registers to m_axis.
// No beat is accepted in a tick's write-back cycle: the ring memory of each lane
// takes a read on the accept cycle and the write-back on the next one (single port).
// Button beats produce no result. Up to 8 tick results may wait unread.
// Reset: rst_n async active low; rings read as zero until filled once, sums,
// digit buffer, scan digit, hold counter and axis clear; hold_ticks = 200.
module accel_average_seven_segment_display_unit #(
    parameter int FILTER_LEN = 50
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] x_sample, [15:8] y_sample, [23:16] z_sample, [24] button_level, rest zero
    input  logic [31:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] com_enable_n, [11:4] segment_drive, [20:12] accel_x,
    // [29:21] accel_y, [38:30] accel_z, [39] zero
    output logic [39:0] m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data     // hold_ticks
);

    localparam int PW   = (FILTER_LEN > 1) ? $clog2(FILTER_LEN) : 1;
    localparam int UW   = $clog2(aasd_pkg::OUT_DEPTH + 1);

    logic                 in_accept;
    logic                 tick;
    logic                 press;
    logic                 pop;

    // front-end control state, updated in beat order
    logic                 busy_reg;          // ring write-back cycle
    logic [UW-1:0]        used_reg;          // ticks accepted, result not yet taken
    logic [PW-1:0]        ptr_reg;
    logic                 wrapped_reg;       // every ring entry written at least once
    logic [1:0]           digit_reg;
    logic [1:0]           digit_next;
    logic [7:0]           hold_reg;
    logic [1:0]           axis_reg;
    logic [7:0]           hold_ticks_reg;

    aasd_pkg::ctrl_t      ctrl_in;
    aasd_pkg::ctrl_t      ctrl_pipe_reg [aasd_pkg::LANE_LAT];

    logic [2:0][7:0]      samples;
    aasd_pkg::lane_res_t [2:0] lane_res;

    logic                 beat_valid;
    aasd_pkg::beat_t      beat;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign tick          = in_accept && (s_axis_tuser == aasd_pkg::REQ_TICK);
    assign press         = in_accept && (s_axis_tuser == aasd_pkg::REQ_BUTTON)
                           && s_axis_tdata[24];
    assign pop           = m_axis_tvalid && m_axis_tready;

    // credits keep every in-flight result a slot in the queue
    assign s_axis_tready = !busy_reg && (used_reg < UW'(aasd_pkg::OUT_DEPTH));
    assign cfg_ready     = 1'b1;

    assign digit_next    = digit_reg + 2'd1;
    assign samples       = s_axis_tdata[23:0];

    // scan position, axis and label choice are fixed when the tick enters
    always_comb
    begin
        ctrl_in.valid = tick;
        ctrl_in.com_n = ~(4'b0001 << digit_next);
        ctrl_in.digit = digit_next;
        ctrl_in.axis  = axis_reg;
        ctrl_in.hold  = (hold_reg != 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            used_reg       <= '0;
            ptr_reg        <= '0;
            wrapped_reg    <= 1'b0;
            digit_reg      <= 2'd0;
            hold_reg       <= 8'd0;
            axis_reg       <= 2'd0;
            hold_ticks_reg <= aasd_pkg::HOLD_RESET;
            for (int i = 0; i < aasd_pkg::LANE_LAT; i++)
            begin
                ctrl_pipe_reg[i] <= '0;
            end
        end
        else
        begin
            busy_reg <= tick;
            used_reg <= used_reg + UW'(tick) - UW'(pop);

            if (cfg_valid)
            begin
                hold_ticks_reg <= cfg_data;
            end

            if (tick)
            begin
                digit_reg <= digit_next;
                if (ptr_reg == PW'(FILTER_LEN - 1))
                begin
                    ptr_reg     <= '0;
                    wrapped_reg <= 1'b1;
                end
                else
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                end
            end

            priority if (press)
            begin
                hold_reg <= hold_ticks_reg;
                axis_reg <= (axis_reg >= aasd_pkg::AXIS_LAST) ? 2'd0 : axis_reg + 2'd1;
            end
            else if (tick && (hold_reg != 8'd0))
            begin
                hold_reg <= hold_reg - 8'd1;
            end

            ctrl_pipe_reg[0] <= ctrl_in;
            for (int i = 1; i < aasd_pkg::LANE_LAT; i++)
            begin
                ctrl_pipe_reg[i] <= ctrl_pipe_reg[i-1];
            end
        end
    end

    // one lane per axis, all started by the same tick
    for (genvar k = 0; k < aasd_pkg::AXES; k++)
    begin : g_lane
        aasd_lane #(
            .FILTER_LEN (FILTER_LEN)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .load   (tick),
            .addr   (ptr_reg),
            .old_ok (wrapped_reg),
            .sample (signed'(samples[k])),
            .res    (lane_res[k])
        );
    end

    aasd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_pipe_reg[aasd_pkg::LANE_LAT-1]),
        .res        (lane_res),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    aasd_fifo #(
        .WIDTH ($bits(aasd_pkg::beat_t)),
        .DEPTH (aasd_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat_valid),
        .wdata     (beat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .rdata     (m_axis_tdata)
    );

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= UW'(aasd_pkg::OUT_DEPTH))
        else $error("credit count above queue depth");

    a_tick_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> !s_axis_tready)
        else $error("beat accepted during ring write-back");

    a_result_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (used_reg != '0))
        else $error("result offered with no tick outstanding");

    a_press_reload: assert property (@(posedge clk) disable iff (!rst_n)
        press |=> (hold_reg == $past(hold_ticks_reg)))
        else $error("hold counter not reloaded on press");

endmodule

/* tb/tb_accel_average_seven_segment_display_unit.sv */
// Self-checking testbench for accel_average_seven_segment_display_unit.
// Drives tick and button beats into the stream port and checks every display beat
// against an in-bench model. Depends on aasd_pkg and the unit's RTL only.
module tb_accel_average_seven_segment_display_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_LEN      = 50;
    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 24;          // margin over the unit's pipeline
    localparam int RX_STALL_CYCLES = 300;         // long enough to fill the result queue
    localparam int PHASE_ITEMS     = 200;
    localparam longint TIME_LIMIT  = 64'd20_000_000;  // ns

    // Scaling of the averaged sample into hundredths of g: avg * 100 / 127
    localparam int G_NUM = 100;
    localparam int G_DEN = 127;

    // ------------------------------------------------------------------
    // Scoreboard: holds its own copy of the unit's state, turns every
    // accepted input beat into the display beat it should cause, and
    // compares output beats against the oldest one still due.
    // ------------------------------------------------------------------
    class accel_display_scoreboard;
        logic signed [7:0] sample_ring [3][FILTER_LEN];
        int                ring_slot;
        int                axis_sum [3];
        logic [7:0]        digit_seg [4];      // digit buffer shown on the next ticks
        logic [1:0]        scan_digit;
        logic [7:0]        label_left;         // ticks the axis label still shows
        logic [1:0]        sel_axis;
        logic [7:0]        hold_ticks;
        logic [7:0]        seg_lut [13];
        aasd_pkg::beat_t   display_due [$];
        int                fails;

        function new();
            seg_lut = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                        8'h7F, 8'h6F, 8'h5C, 8'h40, 8'h00};
            fails = 0;
            clear_state();
        endfunction

        function void clear_state();
            for (int a = 0; a < 3; a++)
            begin
                axis_sum[a] = 0;
                for (int i = 0; i < FILTER_LEN; i++)
                    sample_ring[a][i] = '0;
            end
            for (int d = 0; d < 4; d++)
                digit_seg[d] = '0;
            ring_slot  = 0;
            scan_digit = '0;
            label_left = '0;
            sel_axis   = '0;
            hold_ticks = aasd_pkg::HOLD_RESET;
        endfunction

        function void set_hold_ticks(logic [7:0] v);
            hold_ticks = v;
        endfunction

        function int pending();
            return display_due.size();
        endfunction

        // One accepted input beat: buttons only touch the axis and hold state,
        // ticks scan the display, filter the samples and rebuild the digits.
        function void note_beat(logic req, logic [31:0] data);
            logic signed [7:0] smp [3];
            int                avg;
            int                mag;
            int                v;
            int                val [3];
            int                dot;
            logic [3:0]        sym [4];
            aasd_pkg::beat_t   b;

            if (req == aasd_pkg::REQ_BUTTON)
            begin
                // low level is a release edge and does nothing
                if (data[24])
                begin
                    label_left = hold_ticks;
                    sel_axis   = (sel_axis == aasd_pkg::AXIS_LAST) ? 2'd0 : sel_axis + 2'd1;
                end
                return;
            end

            // scan first, from the buffer built by the previous tick
            scan_digit      = scan_digit + 2'd1;
            b.pad           = 1'b0;
            b.com_enable_n  = ~(4'b0001 << scan_digit);
            b.segment_drive = digit_seg[scan_digit];

            smp[0] = data[7:0];
            smp[1] = data[15:8];
            smp[2] = data[23:16];
            for (int a = 0; a < 3; a++)
            begin
                axis_sum[a] = axis_sum[a] + int'(smp[a]) - int'(sample_ring[a][ring_slot]);
                sample_ring[a][ring_slot] = smp[a];
                avg    = (2 * axis_sum[a]) / FILTER_LEN;   // truncates toward zero
                val[a] = (avg * G_NUM) / G_DEN;
            end
            ring_slot = (ring_slot + 1 >= FILTER_LEN) ? 0 : ring_slot + 1;

            if (label_left != 0)
            begin
                sym[0] = aasd_pkg::SYM_O;
                sym[1] = aasd_pkg::SYM_S;
                sym[2] = aasd_pkg::SYM_BLANK;
                sym[3] = {2'b00, sel_axis};
                dot    = 4;                 // no point while the label shows
                label_left = label_left - 8'd1;
            end
            else
            begin
                v      = val[sel_axis];
                mag    = (v < 0) ? -v : v;
                sym[0] = (v < 0) ? aasd_pkg::SYM_DASH : aasd_pkg::SYM_BLANK;
                sym[1] = 4'((mag / 100) % 10);
                sym[2] = 4'((mag / 10) % 10);
                sym[3] = 4'(mag % 10);
                dot    = 1;
            end
            for (int d = 0; d < 4; d++)
                digit_seg[d] = seg_lut[sym[d]] | ((d == dot) ? aasd_pkg::SEG_DOT : 8'h00);

            b.accel_x = val[0][8:0];
            b.accel_y = val[1][8:0];
            b.accel_z = val[2][8:0];
            display_due.push_back(b);
        endfunction

        task report_mismatch(string what);
            fails++;
            $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_beat(logic [39:0] data);
            aasd_pkg::beat_t got;
            aasd_pkg::beat_t want;

            got = data;
            if (display_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected display beat %h", data));
                return;
            end
            want = display_due.pop_front();
            if (got.com_enable_n !== want.com_enable_n)
                report_mismatch($sformatf("com_enable_n %h, want %h",
                                          got.com_enable_n, want.com_enable_n));
            if (got.segment_drive !== want.segment_drive)
                report_mismatch($sformatf("segment_drive %h, want %h",
                                          got.segment_drive, want.segment_drive));
            if (got.accel_x !== want.accel_x)
                report_mismatch($sformatf("accel_x %h, want %h", got.accel_x, want.accel_x));
            if (got.accel_y !== want.accel_y)
                report_mismatch($sformatf("accel_y %h, want %h", got.accel_y, want.accel_y));
            if (got.accel_z !== want.accel_z)
                report_mismatch($sformatf("accel_z %h, want %h", got.accel_z, want.accel_z));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and its signals
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;

    bit rx_stall_req;   // sender asks the receiver for one long hold-off
    bit no_idle;        // both sides run back to back while set

    accel_display_scoreboard sb = new();

    accel_average_seven_segment_display_unit #(
        .FILTER_LEN (FILTER_LEN)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------
    // Clock and time limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    initial
    begin
        #(TIME_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. An input beat is
    // noted before the output side is looked at; a result never belongs to
    // a beat accepted at the same edge, so the order is harmless anyway.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_beat(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat(m_axis_tdata);
        end
    end

    // ------------------------------------------------------------------
    // Receiver: runs of ready and not-ready of random length, mostly short,
    // now and then long; one long counted hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        int  r;
        int  run_len;
        logic lvl;

        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_stall_req)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (RX_STALL_CYCLES) @(negedge clk);
                rx_stall_req = 1'b0;
            end
            else if (no_idle)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    lvl     = 1'b1;
                    run_len = $urandom_range(1, 20);
                end
                else if (r < 92)
                begin
                    lvl     = 1'b0;
                    run_len = $urandom_range(1, 3);
                end
                else
                begin
                    lvl     = 1'b0;
                    run_len = $urandom_range(10, 60);
                end
                repeat (run_len)
                begin
                    @(negedge clk);
                    m_axis_tready <= lvl;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side tasks. Inputs change on the falling edge; a beat is held
    // until the rising edge that sees tready high.
    // ------------------------------------------------------------------
    function automatic int input_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 70)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic idle_input(int n);
        repeat (n)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
    endtask

    task automatic send_beat(logic req, logic [31:0] data);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // tick: button_level bit is don't-care, so it gets random values
    task automatic send_tick(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        send_beat(aasd_pkg::REQ_TICK, {7'd0, 1'($urandom), z, y, x});
    endtask

    // button: sample lanes are ignored by the unit, fill them with noise
    task automatic send_button(logic level);
        send_beat(aasd_pkg::REQ_BUTTON, {7'd0, level, 24'($urandom)});
    endtask

    // Stop offering and wait until every display beat due has come out,
    // then let in-flight button beats settle.
    task automatic drain_results();
        idle_input(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold(logic [7:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_hold_ticks(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random traffic: runs of ticks in one of several sample patterns so that
    // the 50-deep averages reach the range ends, mixed with button beats.
    task automatic run_random(int count, int phase);
        int                mode;
        int                run_left;
        logic signed [7:0] base [3];
        logic [7:0]        smp [3];

        run_left = 0;
        mode     = 0;
        for (int i = 0; i < count; i++)
        begin
            if (phase == 1 && i == 60)
                rx_stall_req = 1'b1;        // keep offering while the receiver stalls
            if (phase == 2 && i == 100)
                drain_results();            // sender pause until all results are out
            no_idle = (phase == 3 && i < 100);

            if (run_left == 0)
            begin
                mode     = $urandom_range(0, 3);
                run_left = $urandom_range(20, 90);
                for (int a = 0; a < 3; a++)
                begin
                    if (mode == 1)
                        base[a] = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
                    else
                        base[a] = 8'($urandom);
                end
            end
            run_left--;

            if ($urandom_range(0, 99) < 6)
                send_button($urandom_range(0, 99) < 75);
            else
            begin
                for (int a = 0; a < 3; a++)
                begin
                    case (mode)
                        0: smp[a] = 8'($urandom);
                        1: smp[a] = base[a];
                        2: smp[a] = base[a] + 8'($signed($urandom_range(0, 12)) - 6);
                        default: smp[a] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
                    endcase
                end
                send_tick(smp[0], smp[1], smp[2]);
            end
            idle_input(input_gap());
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] hold_plan [6];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        rx_stall_req  = 1'b0;
        no_idle       = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: sample extremes at the reset hold of 200, first scans
        // show the blank buffer from reset.
        send_tick(8'h7F, 8'h80, 8'h00);
        send_tick(8'h80, 8'h7F, 8'hFF);
        send_tick(8'hFF, 8'h01, 8'h55);
        send_tick(8'hAA, 8'h00, 8'h7F);
        send_button(1'b0);              // release edge: nothing happens
        send_button(1'b1);              // select Y, label for 200 ticks
        send_tick(8'h80, 8'h80, 8'h80);
        idle_input(3);
        send_tick(8'h7F, 8'h7F, 8'h7F);
        send_tick(8'h80, 8'h80, 8'h80);
        send_tick(8'h00, 8'h00, 8'h00);
        send_button(1'b1);              // Z
        send_button(1'b1);              // wraps back to X
        send_button(1'b1);              // Y
        send_tick(8'h12, 8'hED, 8'h40);
        idle_input(12);
        send_tick(8'h80, 8'h7F, 8'hC0);
        send_tick(8'h7F, 8'h80, 8'h3F);
        drain_results();

        // Zero hold: a press moves the axis but the label never shows,
        // so the negative value of Z is displayed straight away.
        write_hold(8'd0);
        send_button(1'b1);
        send_tick(8'h80, 8'h80, 8'h80);
        send_tick(8'h80, 8'h80, 8'h80);
        send_tick(8'h80, 8'h80, 8'h80);
        send_tick(8'h01, 8'h02, 8'h80);
        drain_results();

        // Random phases, each under its own hold setting
        hold_plan = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(2, 254)), 8'd3,
                      aasd_pkg::HOLD_RESET};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_hold(hold_plan[ph]);
            run_random(PHASE_ITEMS, ph);
            drain_results();
        end

        if (sb.fails == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/aasd_pkg.sv
hw/rtl/aasd_ram.sv
hw/rtl/aasd_lane.sv
hw/rtl/aasd_merge.sv
hw/rtl/aasd_fifo.sv
hw/rtl/accel_average_seven_segment_display_unit.sv
tb/tb_accel_average_seven_segment_display_unit.sv
